// ===== rtl/smes_pkg.sv =====
`default_nettype none
package smes_pkg;

    localparam int DIM_BITS       = 11;
    localparam int VALUE_BITS     = 32;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [DIM_BITS-1:0] DIM_RESET = 11'd1024;

    localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_BOUNDS = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/smes_req_if.sv =====
`default_nettype none
interface smes_req_if #(
    parameter int INDEX_BITS = 10
);
    import smes_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [INDEX_BITS-1:0] row_index;
    logic [INDEX_BITS-1:0] col_index;
    logic [VALUE_BITS-1:0] write_value;

    modport source (
        output valid, mode, row_index, col_index, write_value,
        input  ready
    );

    modport sink (
        input  valid, mode, row_index, col_index, write_value,
        output ready
    );

endinterface
`default_nettype wire

// ===== rtl/smes_rsp_if.sv =====
`default_nettype none
interface smes_rsp_if;
    import smes_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VALUE_BITS-1:0]  read_value;
    logic [STATUS_BITS-1:0] status;

    modport source (
        output valid, read_value, status,
        input  ready
    );

    modport sink (
        input  valid, read_value, status,
        output ready
    );

endinterface
`default_nettype wire

// ===== rtl/smes_slot_ram.sv =====
`default_nettype none
module smes_slot_ram #(
    parameter int WIDTH     = 53,
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/sparse_matrix_entry_store.sv =====
`default_nettype none
// Channel   Modport  Payload                                    Notes
// request   sink     mode, row_index, col_index, write_value    read or write one element
// result    source   read_value, status                         one per request, registered
// cfg       write    cfg_write_en, cfg_index, cfg_data          row_count, column_count
//
// A request reads the slots in order through the slot table's single read port, one slot
// compared per cycle; a hit ends the scan, a miss compares every slot.
// An out of bounds write skips the scan and goes straight to the decide step.
// After reset a clearing pass writes every slot, with request.ready low.
// A result waiting in the output register does not block a new request; only the final
// step of the next request waits for it to be taken.
module sparse_matrix_entry_store #(
    parameter int SLOT_COUNT = 64,
    parameter int INDEX_BITS = 10
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    smes_req_if.sink                                   request,
    smes_rsp_if.source                                 result,
    input  wire logic                                  cfg_write_en,
    input  wire logic [smes_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [smes_pkg::DIM_BITS-1:0]         cfg_data
);
    import smes_pkg::*;

    localparam int ADDR_BITS = $clog2(SLOT_COUNT);
    localparam int CMP_BITS  = (INDEX_BITS > DIM_BITS) ? INDEX_BITS : DIM_BITS;
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(SLOT_COUNT - 1);

    typedef struct packed {
        logic                  valid;
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        logic [VALUE_BITS-1:0] value;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    state_t state_reg, state_next;

    logic [DIM_BITS-1:0]    row_count_reg;
    logic [DIM_BITS-1:0]    column_count_reg;

    logic [ADDR_BITS-1:0]   scan_addr_reg,  scan_addr_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   check_pend_reg, check_pend_next;
    logic [ADDR_BITS-1:0]   check_addr_reg, check_addr_next;
    logic                   hit_reg,        hit_next;
    logic [ADDR_BITS-1:0]   hit_addr_reg,   hit_addr_next;
    logic [VALUE_BITS-1:0]  hit_value_reg,  hit_value_next;
    logic                   free_found_reg, free_found_next;
    logic [ADDR_BITS-1:0]   free_addr_reg,  free_addr_next;
    logic                   bounds_reg,     bounds_next;

    logic                   op_mode_reg,    op_mode_next;
    logic [INDEX_BITS-1:0]  op_row_reg,     op_row_next;
    logic [INDEX_BITS-1:0]  op_col_reg,     op_col_next;
    logic [VALUE_BITS-1:0]  op_value_reg,   op_value_next;

    logic                   out_valid_reg,  out_valid_next;
    logic [VALUE_BITS-1:0]  out_value_reg,  out_value_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [SLOT_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [SLOT_BITS-1:0]   ram_rdata;

    slot_t                  rd_slot;
    slot_t                  wr_slot;
    logic                   slot_match;
    logic                   req_out_of_bounds;

    smes_slot_ram #(
        .WIDTH     (SLOT_BITS),
        .DEPTH     (SLOT_COUNT),
        .ADDR_BITS (ADDR_BITS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_slot    = slot_t'(ram_rdata);
    assign slot_match = rd_slot.valid && (rd_slot.row == op_row_reg)
                        && (rd_slot.col == op_col_reg);
    assign ram_wdata  = wr_slot;

    assign req_out_of_bounds =
        (CMP_BITS'(request.row_index) >= CMP_BITS'(row_count_reg)) ||
        (CMP_BITS'(request.col_index) >= CMP_BITS'(column_count_reg));

    assign request.ready     = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.read_value = out_value_reg;
    assign result.status     = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_RESET;
            column_count_reg <= DIM_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b0;
            check_pend_reg <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            bounds_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_addr_reg  <= scan_addr_next;
            issue_done_reg <= issue_done_next;
            check_pend_reg <= check_pend_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            bounds_reg     <= bounds_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        check_addr_reg <= check_addr_next;
        hit_addr_reg   <= hit_addr_next;
        hit_value_reg  <= hit_value_next;
        free_addr_reg  <= free_addr_next;
        op_mode_reg    <= op_mode_next;
        op_row_reg     <= op_row_next;
        op_col_reg     <= op_col_next;
        op_value_reg   <= op_value_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        issue_done_next = issue_done_reg;
        check_pend_next = check_pend_reg;
        check_addr_next = check_addr_reg;
        hit_next        = hit_reg;
        hit_addr_next   = hit_addr_reg;
        hit_value_next  = hit_value_reg;
        free_found_next = free_found_reg;
        free_addr_next  = free_addr_reg;
        bounds_next     = bounds_reg;
        op_mode_next    = op_mode_reg;
        op_row_next     = op_row_reg;
        op_col_next     = op_col_reg;
        op_value_next   = op_value_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        ram_we    = 1'b0;
        ram_waddr = scan_addr_reg;
        ram_re    = 1'b0;
        ram_raddr = scan_addr_reg;
        wr_slot   = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // wr_slot stays zero: valid mark cleared
                ram_we = 1'b1;
                if (scan_addr_reg == LAST_ADDR)
                begin
                    scan_addr_next = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (request.valid)
                begin
                    op_mode_next    = request.mode;
                    op_row_next     = request.row_index;
                    op_col_next     = request.col_index;
                    op_value_next   = request.write_value;
                    scan_addr_next  = '0;
                    issue_done_next = 1'b0;
                    check_pend_next = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    bounds_next     = (request.mode == MODE_WRITE) && req_out_of_bounds;
                    if ((request.mode == MODE_WRITE) && req_out_of_bounds)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // read of slot n overlaps the compare of slot n-1
                if (!issue_done_reg)
                begin
                    ram_re          = 1'b1;
                    check_pend_next = 1'b1;
                    check_addr_next = scan_addr_reg;
                    if (scan_addr_reg == LAST_ADDR)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + 1'b1;
                    end
                end
                else
                begin
                    check_pend_next = 1'b0;
                end

                if (check_pend_reg)
                begin
                    if (slot_match)
                    begin
                        hit_next       = 1'b1;
                        hit_addr_next  = check_addr_reg;
                        hit_value_next = rd_slot.value;
                        state_next     = ST_DECIDE;
                    end
                    else
                    begin
                        if (!rd_slot.valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_addr_next  = check_addr_reg;
                        end
                        if (check_addr_reg == LAST_ADDR)
                        begin
                            state_next = ST_DECIDE;
                        end
                    end
                end
            end

            ST_DECIDE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = STATUS_OK;
                    state_next      = ST_IDLE;

                    wr_slot.valid = 1'b1;
                    wr_slot.row   = op_row_reg;
                    wr_slot.col   = op_col_reg;
                    wr_slot.value = op_value_reg;

                    if (op_mode_reg == MODE_READ)
                    begin
                        if (hit_reg)
                        begin
                            out_value_next = hit_value_reg;
                        end
                    end
                    else if (bounds_reg)
                    begin
                        out_status_next = STATUS_BOUNDS;
                    end
                    else if (hit_reg)
                    begin
                        // zero value frees the slot
                        ram_we        = 1'b1;
                        ram_waddr     = hit_addr_reg;
                        wr_slot.valid = (op_value_reg != '0);
                    end
                    else if (op_value_reg != '0)
                    begin
                        if (free_found_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = free_addr_reg;
                        end
                        else
                        begin
                            out_status_next = STATUS_FULL;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
    import smes_pkg::*;

    localparam int ENTRY_SLOTS  = 64;
    localparam int INDEX_W      = 10;
    localparam int SETTLE_TICKS = ENTRY_SLOTS + 8;
    localparam int POOL_SIZE    = 96;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  value;
        logic [STATUS_BITS-1:0] status;
    } outcome_t;

    typedef struct packed {
        bit                     reconfig;
        logic [DIM_BITS-1:0]    rows;
        logic [DIM_BITS-1:0]    cols;
        logic                   mode;
        logic [INDEX_W-1:0]     row;
        logic [INDEX_W-1:0]     col;
        logic [VALUE_BITS-1:0]  data;
        bit                     typed;
        logic [VALUE_BITS-1:0]  exp_value;
        logic [STATUS_BITS-1:0] exp_status;
    } step_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] rows;
        logic [DIM_BITS-1:0] cols;
        int unsigned         items;
        int unsigned         zero_pct;
        int unsigned         hold;
    } phase_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [DIM_BITS-1:0]       cfg_data;

    smes_req_if #(.INDEX_BITS(INDEX_W)) req_ch ();
    smes_rsp_if                         rsp_ch ();

    sparse_matrix_entry_store #(
        .SLOT_COUNT (ENTRY_SLOTS),
        .INDEX_BITS (INDEX_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (req_ch),
        .result       (rsp_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor's copy of the slot table and dimensions
    bit                    entry_used  [ENTRY_SLOTS];
    logic [INDEX_W-1:0]    entry_row   [ENTRY_SLOTS];
    logic [INDEX_W-1:0]    entry_col   [ENTRY_SLOTS];
    logic [VALUE_BITS-1:0] entry_value [ENTRY_SLOTS];
    logic [DIM_BITS-1:0]   row_limit;
    logic [DIM_BITS-1:0]   col_limit;

    outcome_t    pending_results[$];
    int unsigned error_count;
    bit          idle_on;
    int unsigned long_hold;

    // Sideband that travels with each request: a hand-typed expectation
    bit       row_typed;
    outcome_t typed_outcome;

    step_t directed_steps [25] = '{
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd0,    10'd0,    32'h0000_0000,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd1023, 10'd1023, 32'h7FFF_FFFF,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd1023, 10'd1023, 32'h0000_0000,
          1'b1, 32'h7FFF_FFFF, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd0,    10'd0,    32'h8000_0000,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd0,    10'd0,    32'h1234_5678,
          1'b1, 32'h8000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd0,    10'd0,    32'h5555_AAAA,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd0,    10'd0,    32'h0000_0000,
          1'b1, 32'h5555_AAAA, STATUS_OK},
        // zero write on a stored entry frees it
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd0,    10'd0,    32'h0000_0000,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd0,    10'd0,    32'h0000_0000,
          1'b1, 32'h0000_0000, STATUS_OK},
        // zero write with nothing stored
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd5,    10'd5,    32'h0000_0000,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd0,    10'd1023, 32'hFFFF_FFFF,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd0,    10'd1023, 32'h0000_0000,
          1'b1, 32'hFFFF_FFFF, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd1023, 10'd0,    32'h0000_0000,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd1023, 10'd0,    32'h0000_0001,
          1'b0, 32'h0000_0000, STATUS_OK},
        '{1'b1, 11'd1, 11'd1, MODE_WRITE, 10'd1,    10'd0,    32'h0000_0009,
          1'b1, 32'h0000_0000, STATUS_BOUNDS},
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd0,    10'd1,    32'h0000_0009,
          1'b1, 32'h0000_0000, STATUS_BOUNDS},
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd0,    10'd0,    32'h0000_0007,
          1'b1, 32'h0000_0000, STATUS_OK},
        // reads are not bound-checked
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd1023, 10'd1023, 32'h0000_0000,
          1'b0, 32'h0000_0000, STATUS_OK},
        '{1'b1, 11'd0, 11'd0, MODE_WRITE, 10'd0,    10'd0,    32'h0000_0000,
          1'b1, 32'h0000_0000, STATUS_BOUNDS},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd0,    10'd0,    32'h0000_0000,
          1'b0, 32'h0000_0000, STATUS_OK},
        '{1'b1, 11'd2047, 11'd2047, MODE_WRITE, 10'd1023, 10'd1023, 32'h0000_0000,
          1'b1, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd1023, 10'd1023, 32'h0000_0000,
          1'b0, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_WRITE, 10'd1023, 10'd1022, 32'hAAAA_5555,
          1'b0, 32'h0000_0000, STATUS_OK},
        '{1'b1, 11'd1024, 11'd1024, MODE_READ, 10'd1023, 10'd1022, 32'h0000_0000,
          1'b0, 32'h0000_0000, STATUS_OK},
        '{1'b0, 11'd0, 11'd0, MODE_READ,  10'd1023, 10'd0,    32'h0000_0000,
          1'b0, 32'h0000_0000, STATUS_OK}
    };

    phase_t random_phases [9] = '{
        '{11'd1024, 11'd1024, 300, 25, 0},
        '{11'd1024, 11'd1024, 250, 0,  600},  // no deletes: fills the table
        '{11'd8,    11'd8,    250, 40, 0},
        '{11'd1,    11'd1024, 150, 30, 0},
        '{11'd1024, 11'd1,    150, 30, 0},
        '{11'd2047, 11'd2047, 200, 20, 0},
        '{11'd0,    11'd0,    80,  20, 0},
        '{11'd513,  11'd77,   200, 25, 0},
        '{11'd1024, 11'd1024, 250, 25, 0}
    };

    function automatic outcome_t apply_access(input logic m, input logic [INDEX_W-1:0] r,
                                              input logic [INDEX_W-1:0] c,
                                              input logic [VALUE_BITS-1:0] v);
        outcome_t res;
        int       hit;
        int       spare;
        res.value  = '0;
        res.status = STATUS_OK;
        hit        = -1;
        spare      = -1;
        for (int i = 0; i < ENTRY_SLOTS; i++)
        begin
            if (hit < 0 && entry_used[i] && entry_row[i] == r && entry_col[i] == c)
                hit = i;
            if (spare < 0 && !entry_used[i])
                spare = i;
        end
        if (m == MODE_READ)
        begin
            if (hit >= 0)
                res.value = entry_value[hit];
        end
        else if (DIM_BITS'(r) >= row_limit || DIM_BITS'(c) >= col_limit)
            res.status = STATUS_BOUNDS;
        else if (hit >= 0)
        begin
            if (v == '0)
                entry_used[hit] = 1'b0;
            else
                entry_value[hit] = v;
        end
        else if (v != '0)
        begin
            if (spare < 0)
                res.status = STATUS_FULL;
            else
            begin
                entry_used[spare]  = 1'b1;
                entry_row[spare]   = r;
                entry_col[spare]   = c;
                entry_value[spare] = v;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic offer_request(input logic m, input logic [INDEX_W-1:0] r,
                                 input logic [INDEX_W-1:0] c, input logic [VALUE_BITS-1:0] v,
                                 input bit typed, input outcome_t exp);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= m;
        req_ch.row_index   <= r;
        req_ch.col_index   <= c;
        req_ch.write_value <= v;
        row_typed          <= typed;
        typed_outcome      <= exp;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    // Stop offering and let every outstanding request come back
    task automatic settle_block;
        req_ch.valid <= 1'b0;
        // let the watcher queue the last accepted request first
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_dimensions(input logic [DIM_BITS-1:0] rows,
                                  input logic [DIM_BITS-1:0] cols);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_ROW_COUNT;
        cfg_data     <= rows;
        @(posedge clk);
        cfg_index    <= REG_COLUMN_COUNT;
        cfg_data     <= cols;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        row_limit = rows;
        col_limit = cols;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random hold-offs, plus one long stall on request
    initial
    begin
        int unsigned hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                hold_left = long_hold;
                long_hold = 0;
            end
            else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 12);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Check first, then queue: a result can never belong to a request taken this edge
    always @(posedge clk)
    begin : watch_channels
        outcome_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                              rsp_ch.read_value, rsp_ch.status));
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.read_value !== want.value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  rsp_ch.read_value, want.value));
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_ch.status, want.status));
                end
            end
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            begin
                want = apply_access(req_ch.mode, req_ch.row_index, req_ch.col_index,
                                    req_ch.write_value);
                if (row_typed)
                    want = typed_outcome;
                pending_results.push_back(want);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [INDEX_W-1:0]    pool_row [POOL_SIZE];
        logic [INDEX_W-1:0]    pool_col [POOL_SIZE];
        logic [INDEX_W-1:0]    r;
        logic [INDEX_W-1:0]    c;
        logic [VALUE_BITS-1:0] v;
        logic                  m;
        int unsigned           span_r;
        int unsigned           span_c;
        int unsigned           k;
        outcome_t              exp;

        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_index          = REG_ROW_COUNT;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_READ;
        req_ch.row_index   = '0;
        req_ch.col_index   = '0;
        req_ch.write_value = '0;
        row_typed          = 1'b0;
        typed_outcome      = '0;
        error_count        = 0;
        idle_on            = 1'b1;
        long_hold          = 0;
        row_limit          = DIM_RESET;
        col_limit          = DIM_RESET;
        for (int i = 0; i < ENTRY_SLOTS; i++)
        begin
            entry_used[i]  = 1'b0;
            entry_row[i]   = '0;
            entry_col[i]   = '0;
            entry_value[i] = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass keeps request.ready low
        do @(posedge clk); while (req_ch.ready !== 1'b1);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].reconfig)
            begin
                settle_block();
                set_dimensions(directed_steps[i].rows, directed_steps[i].cols);
            end
            exp.value  = directed_steps[i].exp_value;
            exp.status = directed_steps[i].exp_status;
            offer_request(directed_steps[i].mode, directed_steps[i].row,
                          directed_steps[i].col, directed_steps[i].data,
                          directed_steps[i].typed, exp);
        end

        exp = '0;
        foreach (random_phases[p])
        begin
            settle_block();
            set_dimensions(random_phases[p].rows, random_phases[p].cols);
            idle_on = (p != $size(random_phases) - 1);
            long_hold = random_phases[p].hold;
            span_r = (random_phases[p].rows == 0 || random_phases[p].rows > 1024)
                     ? 1024 : random_phases[p].rows;
            span_c = (random_phases[p].cols == 0 || random_phases[p].cols > 1024)
                     ? 1024 : random_phases[p].cols;
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pool_row[i] = INDEX_W'($urandom_range(0, span_r - 1));
                pool_col[i] = INDEX_W'($urandom_range(0, span_c - 1));
            end
            for (int n = 0; n < random_phases[p].items; n++)
            begin
                // mostly a working set of keys so that hits, updates and deletes happen
                if ($urandom_range(0, 99) < 70)
                begin
                    k = $urandom_range(0, POOL_SIZE - 1);
                    r = pool_row[k];
                    c = pool_col[k];
                end
                else
                begin
                    r = INDEX_W'($urandom_range(0, 1023));
                    c = INDEX_W'($urandom_range(0, 1023));
                end
                m = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < random_phases[p].zero_pct)
                    v = '0;
                else
                begin
                    case ($urandom_range(0, 9))
                        0:       v = 32'h7FFF_FFFF;
                        1:       v = 32'h8000_0000;
                        2:       v = 32'hFFFF_FFFF;
                        default: v = $urandom;
                    endcase
                    if (v == '0)
                        v = 32'h0000_0001;
                end
                offer_request(m, r, c, v, 1'b0, exp);
            end
        end

        settle_block();
        if (error_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
